>>> sv/anms_pkg.sv
// package for the ambiguous nucleotide motif search block
// character codes, register map, config struct and the compatibility function
// no dependencies
package anms_pkg;

    localparam int NUM_MOTIF_CHARS = 16;
    localparam int LEN_W           = 5;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 5;

    typedef logic [7:0]       char_t;
    typedef logic [LEN_W-1:0] len_t;

    localparam char_t CH_A    = 8'h41;
    localparam char_t CH_G    = 8'h47;
    localparam char_t CH_C    = 8'h43;
    localparam char_t CH_T    = 8'h54;
    localparam char_t CH_U    = 8'h55;
    localparam char_t CH_I    = 8'h49;
    localparam char_t CH_Y    = 8'h59;
    localparam char_t CH_STAR = 8'h2A;

    typedef enum logic [1:0] {
        REG_MOTIF_LEN   = 2'd0,
        REG_CHARS_LOW   = 2'd1,
        REG_CHARS_HIGH  = 2'd2
    } reg_idx_t;

    typedef logic [NUM_MOTIF_CHARS-1:0][7:0] motif_t;

    typedef struct packed {
        len_t   motif_len;
        motif_t motif_chars;
    } cfg_t;

    // bit0 A, bit1 G, bit2 C, bit3 T/U
    function automatic logic [3:0] base_set(char_t c);
        logic [3:0] s;
        case (c)
            CH_A:    s = 4'b0001;
            CH_G:    s = 4'b0010;
            CH_C:    s = 4'b0100;
            CH_T:    s = 4'b1000;
            CH_U:    s = 4'b1000;
            CH_I:    s = 4'b0011;
            CH_Y:    s = 4'b1100;
            default: s = 4'b0000;
        endcase
        return s;
    endfunction

    function automatic logic plain_base(char_t c);
        return c inside {CH_A, CH_G, CH_C, CH_T, CH_U};
    endfunction

    function automatic logic compatible(char_t x, char_t y);
        logic r;
        if (x == CH_STAR)
        begin
            r = plain_base(y);
        end
        else if (y == CH_STAR)
        begin
            r = plain_base(x);
        end
        else
        begin
            r = |(base_set(x) & base_set(y));
        end
        return r;
    endfunction

endpackage

>>> sv/anms_seq_if.sv
// input channel: one sequence character per beat
// depends on anms_pkg
interface anms_seq_if;
    import anms_pkg::*;

    logic  valid;
    logic  ready;
    char_t seq_char;
    logic  is_last;

    modport source (output valid, output seq_char, output is_last, input ready);
    modport sink   (input valid, input seq_char, input is_last, output ready);
endinterface

>>> sv/anms_match_if.sv
// output channel: one match result per beat
// no dependencies
interface anms_match_if;
    logic valid;
    logic ready;
    logic window_hit;
    logic found_so_far;
    logic end_of_seq;

    modport source (output valid, output window_hit, output found_so_far,
                    output end_of_seq, input ready);
    modport sink   (input valid, input window_hit, input found_so_far,
                    input end_of_seq, output ready);
endinterface

>>> sv/anms_cfg.sv
// apb register file: motif length and the sixteen motif characters
// depends on anms_pkg
module anms_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [anms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [anms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [anms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output anms_pkg::cfg_t                     cfg
);
    import anms_pkg::*;

    len_t                  motif_len_reg;
    logic [APB_DATA_W-1:0] chars_low_reg;
    logic [APB_DATA_W-1:0] chars_high_reg;
    reg_idx_t              idx;
    logic                  wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_len_reg  <= len_t'(1);
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MOTIF_LEN:  motif_len_reg  <= pwdata[LEN_W-1:0];
                REG_CHARS_LOW:  chars_low_reg  <= pwdata;
                REG_CHARS_HIGH: chars_high_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MOTIF_LEN:  prdata = APB_DATA_W'(motif_len_reg);
            REG_CHARS_LOW:  prdata = chars_low_reg;
            REG_CHARS_HIGH: prdata = chars_high_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.motif_len   = motif_len_reg;
    assign cfg.motif_chars = {chars_high_reg, chars_low_reg};

endmodule

>>> sv/anms_cell.sv
// one window cell: holds a character, passes it on, and checks the incoming
// character against its motif character; depends on anms_pkg
module anms_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  logic            in_use,
    input  anms_pkg::char_t char_in,
    input  anms_pkg::char_t motif_char,
    output anms_pkg::char_t char_out,
    output logic            match
);
    import anms_pkg::*;

    char_t char_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            char_reg <= char_in;
        end
    end

    assign char_out = char_reg;
    // unused cells never block a hit
    assign match    = !in_use || compatible(char_in, motif_char);

endmodule

>>> sv/ambiguous_nucleotide_motif_search.sv
// result: the result beat of an accepted character beat is registered and offered in the cycle after it
// throughput: one character per cycle; the cells compare in parallel and a new
// beat enters in the cycle the previous result leaves, a waiting result holds it off
// reset: window contents undefined, fill count, found flag and output valid
// cleared; motif length 1, motif characters zero
module ambiguous_nucleotide_motif_search #(
    parameter int MAX_MOTIF_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [anms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [anms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [anms_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    anms_seq_if.sink                        seq_in,
    anms_match_if.source                    match_out
);
    import anms_pkg::*;

    localparam int   FILL_W  = $clog2(MAX_MOTIF_LEN + 1);
    localparam len_t MAX_LEN = LEN_W'(MAX_MOTIF_LEN);

    cfg_t                    cfg;
    len_t                    eff_len;
    logic                    accept;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic                    found_flag_reg;
    logic                    found_next;
    logic                    hit;
    logic                    out_valid_reg;
    logic                    hit_reg;
    logic                    found_out_reg;
    logic                    eos_reg;
    char_t                   chain [MAX_MOTIF_LEN];
    logic [MAX_MOTIF_LEN-1:0] cell_match;

    anms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign eff_len = (cfg.motif_len > MAX_LEN) ? MAX_LEN : cfg.motif_len;

    assign seq_in.ready = !out_valid_reg || match_out.ready;
    assign accept       = seq_in.valid && seq_in.ready;

    for (genvar k = 0; k < MAX_MOTIF_LEN; k++)
    begin : g_cell
        char_t cin;
        len_t  sel;
        logic  use_k;

        assign use_k = len_t'(k) < eff_len;
        // cell k checks its incoming character against motif position len-1-k
        assign sel   = eff_len - len_t'(k) - len_t'(1);

        if (k == 0)
        begin : g_head
            assign cin = seq_in.seq_char;
        end
        else
        begin : g_body
            assign cin = chain[k-1];
        end

        anms_cell u_cell (
            .clk        (clk),
            .shift_en   (accept),
            .in_use     (use_k),
            .char_in    (cin),
            .motif_char (cfg.motif_chars[sel[3:0]]),
            .char_out   (chain[k]),
            .match      (cell_match[k])
        );
    end

    assign fill_next  = (fill_reg == FILL_W'(MAX_MOTIF_LEN)) ? fill_reg
                                                             : fill_reg + FILL_W'(1);
    assign hit        = (&cell_match) && (LEN_W'(fill_next) >= eff_len);
    assign found_next = found_flag_reg || hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            found_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg       <= seq_in.is_last ? '0 : fill_next;
                found_flag_reg <= seq_in.is_last ? 1'b0 : found_next;
                out_valid_reg  <= 1'b1;
            end
            else if (match_out.ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg       <= hit;
            found_out_reg <= found_next;
            eos_reg       <= seq_in.is_last;
        end
    end

    assign match_out.valid        = out_valid_reg;
    assign match_out.window_hit   = hit_reg;
    assign match_out.found_so_far = found_out_reg;
    assign match_out.end_of_seq   = eos_reg;

endmodule
